[rtl/kqw_pkg.sv]
// Shared types for the keyboard queue with blocked readers.
// Opcodes, reply codes, controller states and the command/status structs.
// No dependencies.
`default_nettype none

package kqw_pkg;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_KEY   = 2'd1,
        OP_ABORT = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_BYTE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_QFULL = 2'd2
    } t_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_REPLY_EMPTY,
        S_REPLY_QFULL,
        S_DR_RD,
        S_DR_LD,
        S_KEY_RD,
        S_KEY_LD,
        S_SH_RD,
        S_SH_WR,
        S_AB_RD,
        S_AB_CMP
    } t_state;

    typedef struct packed {
        logic  cap;       // capture input item
        logic  enq;       // append reader tag to waiter queue
        logic  push;      // buffer keystroke at head
        logic  set_run;   // compute drain length
        logic  krd;       // read key store at tail
        logic  dload;     // load drained byte into output, advance tail
        logic  rload;     // load single status reply
        t_stat rstat;
        logic  wrd;       // read waiter store at index
        logic  kload;     // load keystroke delivery to oldest waiter
        logic  wshift;    // write waiter data one slot down, advance index
        logic  wdec;      // drop one waiter from count
        logic  idx_zero;
        logic  idx_one;
        logic  idx_inc;
    } t_cmd;

    typedef struct packed {
        logic scr_ok;
        t_op  op;
        logic fill_zero;
        logic want_zero;
        logic wq_full;
        logic wq_empty;
        logic buf_full;
        logic run_last;
        logic out_free;
        logic tag_match;
        logic idx_end;
    } t_sts;

endpackage

`default_nettype wire

[rtl/kqw_ctrl.sv]
// Controller state machine for the keyboard queue.
// Depends on kqw_pkg; drives commands into kqw_dp and reads its status.
`default_nettype none

module kqw_ctrl
    import kqw_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.rstat = ST_BYTE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                if (i_sts.scr_ok) begin
                    case (i_sts.op)
                        OP_READ: begin
                            if (!i_sts.fill_zero) begin
                                o_cmd.set_run = 1'b1;
                                n_state       = S_DR_RD;
                            end else if (i_sts.want_zero) begin
                                n_state = S_REPLY_EMPTY;
                            end else if (i_sts.wq_full) begin
                                n_state = S_REPLY_QFULL;
                            end else begin
                                o_cmd.enq = 1'b1;
                            end
                        end
                        OP_KEY: begin
                            if (!i_sts.wq_empty) begin
                                o_cmd.idx_zero = 1'b1;
                                n_state        = S_KEY_RD;
                            end else if (!i_sts.buf_full) begin
                                o_cmd.push = 1'b1;
                            end
                        end
                        OP_ABORT: begin
                            o_cmd.idx_zero = 1'b1;
                            n_state        = S_AB_RD;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_REPLY_EMPTY: begin
                if (i_sts.out_free) begin
                    o_cmd.rload = 1'b1;
                    o_cmd.rstat = ST_EMPTY;
                    n_state     = S_IDLE;
                end
            end
            S_REPLY_QFULL: begin
                if (i_sts.out_free) begin
                    o_cmd.rload = 1'b1;
                    o_cmd.rstat = ST_QFULL;
                    n_state     = S_IDLE;
                end
            end
            S_DR_RD: begin
                o_cmd.krd = 1'b1;
                n_state   = S_DR_LD;
            end
            S_DR_LD: begin
                if (i_sts.out_free) begin
                    o_cmd.dload = 1'b1;
                    n_state     = i_sts.run_last ? S_IDLE : S_DR_RD;
                end
            end
            S_KEY_RD: begin
                o_cmd.wrd = 1'b1;
                n_state   = S_KEY_LD;
            end
            S_KEY_LD: begin
                if (i_sts.out_free) begin
                    o_cmd.kload   = 1'b1;
                    o_cmd.idx_one = 1'b1;
                    n_state       = S_SH_RD;
                end
            end
            S_SH_RD: begin
                if (i_sts.idx_end) begin
                    o_cmd.wdec = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.wrd = 1'b1;
                    n_state   = S_SH_WR;
                end
            end
            S_SH_WR: begin
                o_cmd.wshift = 1'b1;
                n_state      = S_SH_RD;
            end
            S_AB_RD: begin
                if (i_sts.idx_end) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.wrd = 1'b1;
                    n_state   = S_AB_CMP;
                end
            end
            S_AB_CMP: begin
                // close the gap behind a matching tag
                o_cmd.idx_inc = 1'b1;
                n_state       = i_sts.tag_match ? S_SH_RD : S_AB_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

[rtl/kqw_dp.sv]
// Datapath: item register, per-screen pointers and counts, key and waiter
// stores, output register. Depends on kqw_pkg; driven by kqw_ctrl.
`default_nettype none

module kqw_dp
    import kqw_pkg::*;
#(
    parameter int BUF_DEPTH   = 64,
    parameter int NUM_SCREENS = 8,
    parameter int MAX_WAITERS = 8
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    input  wire [1:0]  i_opcode,
    input  wire [2:0]  i_screen_index,
    input  wire [7:0]  i_reader_tag,
    input  wire [15:0] i_want_count,
    input  wire [7:0]  i_key_byte,
    input  wire        i_out_ready,
    output logic       o_out_valid,
    output logic [7:0] o_dest_reader,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_reply_status,
    output logic       o_last_of_reply
);

    localparam int PW   = $clog2(BUF_DEPTH);
    localparam int SW   = (NUM_SCREENS > 1) ? $clog2(NUM_SCREENS) : 1;
    localparam int WCW  = $clog2(MAX_WAITERS + 1);
    localparam int KDEP = NUM_SCREENS * BUF_DEPTH;
    localparam int KAW  = $clog2(KDEP);
    localparam int WDEP = NUM_SCREENS * MAX_WAITERS;
    localparam int WAW  = (WDEP > 1) ? $clog2(WDEP) : 1;

    // item register
    t_op             r_op;
    logic [SW-1:0]   r_scr;
    logic            r_scr_ok;
    logic [7:0]      r_tag;
    logic [15:0]     r_want;
    logic [7:0]      r_key;

    logic [PW-1:0]   r_head [NUM_SCREENS];
    logic [PW-1:0]   r_tail [NUM_SCREENS];
    logic [PW:0]     r_fill [NUM_SCREENS];
    logic [WCW-1:0]  r_wcnt [NUM_SCREENS];

    logic [PW:0]     r_run;
    logic [WCW-1:0]  r_idx;

    logic [7:0]      r_kmem [KDEP];
    logic [7:0]      r_krdata;
    logic [7:0]      r_wmem [WDEP];
    logic [7:0]      r_wrdata;

    logic [PW-1:0]   cur_head, cur_tail, tail_nxt;
    logic [PW:0]     cur_fill, run_avail, n_run;
    logic [WCW-1:0]  cur_wcnt;
    logic [KAW-1:0]  k_base;
    logic [WAW-1:0]  w_base, w_waddr;
    logic            w_we;
    logic            out_free;

    assign cur_head = r_head[r_scr];
    assign cur_tail = r_tail[r_scr];
    assign cur_fill = r_fill[r_scr];
    assign cur_wcnt = r_wcnt[r_scr];
    assign tail_nxt = (cur_tail == PW'(BUF_DEPTH - 1)) ? '0 : cur_tail + 1'b1;

    // contiguous run from tail: up to head, or to the end of the ring
    assign run_avail = (cur_head > cur_tail) ? {1'b0, cur_head - cur_tail}
                                             : (PW+1)'(BUF_DEPTH) - {1'b0, cur_tail};
    always_comb begin
        if (r_want == '0) begin
            n_run = cur_fill;
        end else if (r_want < 16'(run_avail)) begin
            n_run = (PW+1)'(r_want);
        end else begin
            n_run = run_avail;
        end
    end

    assign k_base = KAW'(32'(r_scr) * BUF_DEPTH);
    assign w_base = WAW'(32'(r_scr) * MAX_WAITERS);
    assign w_we   = i_cmd.enq | i_cmd.wshift;
    assign w_waddr = i_cmd.enq ? w_base + WAW'(cur_wcnt) : w_base + WAW'(r_idx - 1'b1);

    assign out_free = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op     <= t_op'(i_opcode);
            r_scr    <= SW'(i_screen_index);
            r_scr_ok <= (32'(i_screen_index) < NUM_SCREENS);
            r_tag    <= i_reader_tag;
            r_want   <= i_want_count;
            r_key    <= i_key_byte;
        end
        if (i_cmd.set_run) begin
            r_run <= n_run;
        end else if (i_cmd.dload) begin
            r_run <= r_run - 1'b1;
        end
        if (i_cmd.idx_zero) begin
            r_idx <= '0;
        end else if (i_cmd.idx_one) begin
            r_idx <= WCW'(1);
        end else if (i_cmd.idx_inc || i_cmd.wshift) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // per-screen control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SCREENS; s++) begin
                r_head[s] <= '0;
                r_tail[s] <= '0;
                r_fill[s] <= '0;
                r_wcnt[s] <= '0;
            end
        end else begin
            if (i_cmd.push) begin
                r_head[r_scr] <= (cur_head == PW'(BUF_DEPTH - 1)) ? '0 : cur_head + 1'b1;
                r_fill[r_scr] <= cur_fill + 1'b1;
            end
            if (i_cmd.dload) begin
                r_tail[r_scr] <= tail_nxt;
                r_fill[r_scr] <= cur_fill - 1'b1;
            end
            if (i_cmd.enq) begin
                r_wcnt[r_scr] <= cur_wcnt + 1'b1;
            end
            if (i_cmd.wdec) begin
                r_wcnt[r_scr] <= cur_wcnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_kmem[k_base + KAW'(cur_head)] <= r_key;
        end
        if (i_cmd.krd) begin
            r_krdata <= r_kmem[k_base + KAW'(cur_tail)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_wmem[w_waddr] <= i_cmd.enq ? r_tag : r_wrdata;
        end
        if (i_cmd.wrd) begin
            r_wrdata <= r_wmem[w_base + WAW'(r_idx)];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.rload || i_cmd.kload || i_cmd.dload) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rload) begin
            o_dest_reader   <= r_tag;
            o_out_byte      <= '0;
            o_reply_status  <= i_cmd.rstat;
            o_last_of_reply <= 1'b1;
        end else if (i_cmd.kload) begin
            o_dest_reader   <= r_wrdata;
            o_out_byte      <= r_key;
            o_reply_status  <= ST_BYTE;
            o_last_of_reply <= 1'b1;
        end else if (i_cmd.dload) begin
            o_dest_reader   <= r_tag;
            o_out_byte      <= r_krdata;
            o_reply_status  <= ST_BYTE;
            o_last_of_reply <= (r_run == (PW+1)'(1));
        end
    end

    always_comb begin
        o_sts.scr_ok    = r_scr_ok;
        o_sts.op        = r_op;
        o_sts.fill_zero = (cur_fill == '0);
        o_sts.want_zero = (r_want == '0);
        o_sts.wq_full   = (32'(cur_wcnt) >= MAX_WAITERS);
        o_sts.wq_empty  = (cur_wcnt == '0);
        o_sts.buf_full  = (32'(cur_fill) >= BUF_DEPTH);
        o_sts.run_last  = (r_run == (PW+1)'(1));
        o_sts.out_free  = out_free;
        o_sts.tag_match = (r_wrdata == r_tag);
        o_sts.idx_end   = (r_idx >= cur_wcnt);
    end

`ifndef SYNTHESIS
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (32'(cur_fill) < BUF_DEPTH))
        else $error("keystroke buffered into full ring");
    a_enq_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.enq |-> (32'(cur_wcnt) < MAX_WAITERS))
        else $error("reader queued into full waiter queue");
    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.dload |-> (r_run != '0 && cur_fill != '0))
        else $error("drain past end of buffered data");
    a_wdec_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wdec |-> (cur_wcnt != '0))
        else $error("waiter removed from empty queue");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.dload || i_cmd.kload || i_cmd.rload) |-> out_free)
        else $error("output register overwritten before transfer");
`endif

endmodule

`default_nettype wire

[rtl/keyboard_queue_with_waiters_top.sv]
// An item is accepted in idle and decoded the cycle after. A buffered keystroke or
// queued read completes in the decode state. A drained read alternates a key store
// read and an output load for each byte; each load waits for a free output register.
// Keystroke to a waiter or abort: a walk of the waiter store, one queued tag at a time.
// Synchronous active-low reset clears pointers, counts and the output valid;
// key and waiter stores are not cleared.
`default_nettype none

module keyboard_queue_with_waiters_top
    import kqw_pkg::*;
#(
    parameter int BUF_DEPTH   = 64,
    parameter int NUM_SCREENS = 8,
    parameter int MAX_WAITERS = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [39:0] s_axis_tdata,  // screen_index[2:0], reader_tag[10:3],
                                       // want_count[26:11], key_byte[34:27], zero pad
    input  wire  [1:0]  s_axis_tuser,  // opcode[1:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,  // dest_reader[7:0], out_byte[15:8]
    output logic [1:0]  m_axis_tuser,  // reply_status[1:0]
    output logic        m_axis_tlast   // last_of_reply
);

    t_cmd cmd;
    t_sts sts;

    kqw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    kqw_dp #(
        .BUF_DEPTH   (BUF_DEPTH),
        .NUM_SCREENS (NUM_SCREENS),
        .MAX_WAITERS (MAX_WAITERS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_opcode        (s_axis_tuser),
        .i_screen_index  (s_axis_tdata[2:0]),
        .i_reader_tag    (s_axis_tdata[10:3]),
        .i_want_count    (s_axis_tdata[26:11]),
        .i_key_byte      (s_axis_tdata[34:27]),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_dest_reader   (m_axis_tdata[7:0]),
        .o_out_byte      (m_axis_tdata[15:8]),
        .o_reply_status  (m_axis_tuser),
        .o_last_of_reply (m_axis_tlast)
    );

endmodule

`default_nettype wire

[test/tb_top.sv]
// Self-checking bench for keyboard_queue_with_waiters_top: a queued stream driver,
// a per-screen keystroke/waiter predictor and a reply monitor.
// Depends on kqw_pkg and the top-level RTL.
`default_nettype none

module tb_top;
    import kqw_pkg::*;

    localparam int DEPTH   = 64;
    localparam int SCREENS = 8;
    localparam int WAITERS = 8;

    typedef struct {
        logic [1:0]  opcode;
        logic [2:0]  scr;
        logic [7:0]  tag;
        logic [15:0] want;
        logic [7:0]  key;
        bit          sync;  // hold until every reply is in
    } t_req;

    typedef struct {
        logic [7:0] dest;
        logic [7:0] data;
        logic [1:0] stat;
        logic       last;
    } t_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [39:0] s_tdata = '0;  // screen_index, reader_tag, want_count, key_byte, pad
    logic [1:0]  s_tuser = '0;  // opcode
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [15:0] m_tdata;       // dest_reader, out_byte
    wire  [1:0]  m_tuser;       // reply_status
    wire         m_tlast;

    t_req   pending_reqs[$];
    t_reply want_replies[$];
    t_req   cur_req;
    int     errors = 0;
    int     s_gap = 0;
    int     r_gap = 0;

    // predictor state
    logic [7:0] keys[SCREENS][DEPTH];
    int         head[SCREENS];
    int         tail[SCREENS];
    int         fill[SCREENS];
    logic [7:0] waitq[SCREENS][WAITERS];
    int         wcnt[SCREENS];

    keyboard_queue_with_waiters_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    always #6 i_clk = ~i_clk;

    function automatic void push_reply(logic [7:0] d, logic [7:0] b, t_stat st, logic l);
        t_reply r;
        r.dest = d;
        r.data = b;
        r.stat = st;
        r.last = l;
        want_replies.push_back(r);
    endfunction

    function automatic void drain_keys(int s, int n, logic [7:0] tag);
        for (int i = 0; i < n; i++) begin
            push_reply(tag, keys[s][tail[s]], ST_BYTE, i == n - 1);
            tail[s] = (tail[s] + 1) % DEPTH;
        end
        fill[s] -= n;
    endfunction

    function automatic void predict_replies(t_req q);
        int s;
        int run;
        bit hit;
        s = q.scr;
        hit = 0;
        if (s >= SCREENS) return;
        if (q.opcode == OP_READ) begin
            if (fill[s] == 0) begin
                if (q.want == 0) push_reply(q.tag, 8'd0, ST_EMPTY, 1'b1);
                else if (wcnt[s] >= WAITERS) push_reply(q.tag, 8'd0, ST_QFULL, 1'b1);
                else begin
                    waitq[s][wcnt[s]] = q.tag;
                    wcnt[s]++;
                end
            end else if (q.want == 0) begin
                drain_keys(s, fill[s], q.tag);
            end else begin
                run = (head[s] > tail[s]) ? head[s] - tail[s] : DEPTH - tail[s];
                if (run > q.want) run = q.want;
                drain_keys(s, run, q.tag);
            end
        end else if (q.opcode == OP_KEY) begin
            if (wcnt[s] > 0) begin
                push_reply(waitq[s][0], q.key, ST_BYTE, 1'b1);
                for (int i = 1; i < wcnt[s]; i++) waitq[s][i-1] = waitq[s][i];
                wcnt[s]--;
            end else if (fill[s] < DEPTH) begin
                keys[s][head[s]] = q.key;
                head[s] = (head[s] + 1) % DEPTH;
                fill[s]++;
            end
        end else if (q.opcode == OP_ABORT) begin
            for (int i = 0; i < wcnt[s]; i++) begin
                if (!hit && waitq[s][i] == q.tag) begin
                    for (int j = i + 1; j < wcnt[s]; j++) waitq[s][j-1] = waitq[s][j];
                    wcnt[s]--;
                    hit = 1;
                end
            end
        end
    endfunction

    task automatic add_req(logic [1:0] op, logic [2:0] scr, logic [7:0] tag,
                           logic [15:0] want, logic [7:0] key, bit sync = 0);
        t_req q;
        q.opcode = op;
        q.scr    = scr;
        q.tag    = tag;
        q.want   = want;
        q.key    = key;
        q.sync   = sync;
        pending_reqs.push_back(q);
    endtask

    function automatic logic [15:0] rand_want();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hFFFF;
            3: return 16'($urandom_range(1, 8));
            default: return 16'($urandom);
        endcase
    endfunction

    // stream driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_gap > 0) begin
                s_gap    <= s_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0 && pending_reqs[0].sync &&
                         (s_tvalid || want_replies.size() > 0)) begin
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 40 && $urandom_range(0, 5) == 0) begin
                s_gap    <= $urandom_range(0, 16);
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                cur_req  <= pending_reqs[0];
                s_tdata  <= {5'd0, pending_reqs[0].key, pending_reqs[0].want,
                             pending_reqs[0].tag, pending_reqs[0].scr};
                s_tuser  <= pending_reqs[0].opcode;
                s_tvalid <= 1'b1;
                void'(pending_reqs.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (r_gap > 0) begin
            r_gap    <= r_gap - 1;
            m_tready <= 1'b0;
        end else if (pending_reqs.size() > 40 && $urandom_range(0, 5) == 0) begin
            r_gap    <= $urandom_range(0, 16);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // monitor: predict on input transfer, check on output transfer
    always @(posedge i_clk) begin
        t_reply r;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) predict_replies(cur_req);
            if (m_tvalid && m_tready) begin
                if (want_replies.size() == 0) begin
                    $error("unexpected reply dest=%0d byte=%0d", m_tdata[7:0], m_tdata[15:8]);
                    errors++;
                end else begin
                    r = want_replies.pop_front();
                    if (m_tdata[7:0] !== r.dest) begin
                        $error("dest_reader exp %0d got %0d", r.dest, m_tdata[7:0]);
                        errors++;
                    end
                    if (m_tdata[15:8] !== r.data) begin
                        $error("out_byte exp %0d got %0d", r.data, m_tdata[15:8]);
                        errors++;
                    end
                    if (m_tuser !== r.stat) begin
                        $error("reply_status exp %0d got %0d", r.stat, m_tuser);
                        errors++;
                    end
                    if (m_tlast !== r.last) begin
                        $error("last_of_reply exp %0d got %0d", r.last, m_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        int kind;
        int scr;
        int n;
        int cnt;
        for (int s = 0; s < SCREENS; s++) begin
            head[s] = 0;
            tail[s] = 0;
            fill[s] = 0;
            wcnt[s] = 0;
        end
        // directed: empty replies, waiters, queue full, aborts, ignored opcode
        add_req(OP_READ, 3'd0, 8'd0, 16'd0, 8'd0);
        add_req(OP_READ, 3'd7, 8'd255, 16'hFFFF, 8'd255);
        add_req(OP_KEY, 3'd7, 8'd0, 16'd0, 8'd255);
        for (int i = 0; i < 9; i++) add_req(OP_READ, 3'd1, 8'(i * 31), 16'd1, 8'd0);
        add_req(OP_ABORT, 3'd1, 8'd62, 16'd0, 8'd0);
        add_req(OP_ABORT, 3'd1, 8'd200, 16'd0, 8'd0);
        add_req(2'd3, 3'd1, 8'd0, 16'hFFFF, 8'hFF);
        add_req(OP_KEY, 3'd1, 8'hFF, 16'hFFFF, 8'd0);
        add_req(OP_KEY, 3'd0, 8'd0, 16'd0, 8'd0);
        add_req(OP_KEY, 3'd0, 8'd0, 16'd0, 8'd255);
        add_req(OP_KEY, 3'd0, 8'd0, 16'd0, 8'd170);
        add_req(OP_READ, 3'd0, 8'd9, 16'd1, 8'd0);
        add_req(OP_READ, 3'd0, 8'd10, 16'hFFFF, 8'd0, 1);
        add_req(OP_READ, 3'd0, 8'd11, 16'd0, 8'd0);
        // flood one screen past full, then drain it in runs
        for (int i = 0; i < 66; i++) add_req(OP_KEY, 3'd2, 8'd0, 16'd0, 8'($urandom));
        add_req(OP_READ, 3'd2, 8'd5, 16'd3, 8'd0);
        add_req(OP_READ, 3'd2, 8'd6, 16'd0, 8'd0, 1);
        cnt = 0;
        while (cnt < 230) begin
            kind = $urandom_range(0, 9);
            scr  = $urandom_range(0, SCREENS - 1);
            if (kind < 4) begin
                n = $urandom_range(1, 10);
                for (int i = 0; i < n; i++) add_req(OP_KEY, 3'(scr), 8'($urandom), 16'($urandom),
                                                    8'($urandom));
                add_req(OP_READ, 3'(scr), 8'($urandom), rand_want(), 8'($urandom));
                cnt += n + 1;
            end else if (kind < 7) begin
                n = $urandom_range(1, 9);
                for (int i = 0; i < n; i++)
                    add_req(OP_READ, 3'(scr), 8'($urandom_range(0, 3)), 16'($urandom_range(1, 65535)),
                            8'($urandom));
                if ($urandom_range(0, 1))
                    add_req(OP_ABORT, 3'(scr), 8'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
                for (int i = 0; i < n; i++) add_req(OP_KEY, 3'(scr), 8'($urandom), 16'($urandom),
                                                    8'($urandom));
                cnt += 2 * n + 1;
            end else begin
                add_req(2'($urandom), 3'(scr), 8'($urandom), rand_want(), 8'($urandom));
                cnt++;
            end
        end
        // drain whatever is still buffered on every screen at the end; waiting readers stay queued
        for (int s = 0; s < SCREENS; s++) add_req(OP_READ, 3'(s), 8'd77, 16'd0, 8'd0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_reqs.size() > 0 || s_tvalid || want_replies.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (want_replies.size() > 0) begin
            $error("%0d replies never arrived", want_replies.size());
            errors++;
        end
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #30000000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
